>>> rtl/core/pip_pkg.sv
// ============================================================================
// pip_pkg - point-in-polygon test shared definitions
// Sizes, item operation codes and the queue entry type used by the core.
// ============================================================================
package pip_pkg;

    localparam int MAX_VERTICES_DEF = 64;

    localparam int COORD_W = 16;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // operation codes carried through the queue
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_DROP  = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } pip_item_t;

endpackage

>>> rtl/core/pip_front.sv
// ============================================================================
// pip_front - input side of the point-in-polygon core
// Holds the vertex count register, accepts items and tags each one.
// ============================================================================
module pip_front #(
    parameter int  MaxVertices = pip_pkg::MAX_VERTICES_DEF,
    localparam int CntW        = $clog2(MaxVertices + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                kind,
    input  logic [pip_pkg::SLOT_W-1:0]          vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [pip_pkg::COORD_W-1:0]  y_coord,
    output logic                                q_push,
    output pip_pkg::pip_item_t                  q_push_item,
    input  logic                                q_full,
    output logic [CntW-1:0]                     vertex_count
);

    logic [pip_pkg::COUNT_W-1:0] num_vertices_reg;
    logic                        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vertices_reg <= '0;
        end
        else if (cfg_wr)
        begin
            num_vertices_reg <= pwdata[pip_pkg::COUNT_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0
                             : {{(32 - pip_pkg::COUNT_W){1'b0}}, num_vertices_reg};

    // count above the table size saturates
    assign vertex_count = (int'(num_vertices_reg) > MaxVertices)
                          ? CntW'(MaxVertices) : CntW'(num_vertices_reg);

    always_comb
    begin
        q_push_item.slot = vertex_index;
        q_push_item.x    = x_coord;
        q_push_item.y    = y_coord;
        if (kind)
        begin
            q_push_item.op = pip_pkg::OP_QUERY;
        end
        else if (int'(vertex_index) < MaxVertices)
        begin
            q_push_item.op = pip_pkg::OP_WRITE;
        end
        else
        begin
            q_push_item.op = pip_pkg::OP_DROP;
        end
    end

    assign q_push     = item_valid && !q_full;
    assign item_stall = q_full;

endmodule

>>> rtl/core/pip_queue.sv
// ============================================================================
// pip_queue - item queue between front and back
// Small register FIFO; the head entry is shown while not empty.
// ============================================================================
module pip_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pip_pkg::pip_item_t push_item,
    output logic               full,
    input  logic               pop,
    output pip_pkg::pip_item_t pop_item,
    output logic               empty
);

    localparam logic [pip_pkg::QPTR_W-1:0] LastPtr = pip_pkg::QPTR_W'(pip_pkg::QUEUE_DEPTH - 1);

    pip_pkg::pip_item_t           entry_reg [pip_pkg::QUEUE_DEPTH];
    logic [pip_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [pip_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [pip_pkg::QCNT_W-1:0]   count_reg, count_next;
    logic                         do_push, do_pop;

    assign full     = (count_reg == pip_pkg::QCNT_W'(pip_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> rtl/core/pip_back.sv
// ============================================================================
// pip_back - vertex table and edge walk
// Stores vertices, walks the edges of a query one per cycle through a
// two-stage compare pipeline, and holds the result until it is taken.
// ============================================================================
module pip_back #(
    parameter int  MaxVertices = pip_pkg::MAX_VERTICES_DEF,
    localparam int CntW        = $clog2(MaxVertices + 1),
    localparam int AddrW       = $clog2(MaxVertices),
    localparam int StepW       = $clog2(MaxVertices + 2)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  pip_pkg::pip_item_t q_item,
    output logic               q_pop,
    input  logic [CntW-1:0]    vertex_count,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               inside_res,
    output logic               on_boundary
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WALK   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    localparam int CW = pip_pkg::COORD_W;

    logic signed [CW-1:0] mem_x [MaxVertices];
    logic signed [CW-1:0] mem_y [MaxVertices];

    logic [1:0]            state_reg, state_next;
    logic [StepW-1:0]      step_reg, step_next;
    logic [CntW-1:0]       n_reg;
    logic signed [CW-1:0]  px_reg, py_reg;
    logic                  inside_reg, hit_reg;

    logic                  s1_v_reg, s1_first_reg;
    logic signed [CW-1:0]  rd_x_reg, rd_y_reg;
    logic signed [CW-1:0]  prev_x_reg, prev_y_reg;

    logic                  s2_v_reg, s2_edge_hit_reg, s2_straddle_reg, s2_neg_reg;
    logic signed [2*CW+1:0] lhs_reg, rhs_reg;

    logic                  res_valid_reg, res_inside_reg, res_bnd_reg;

    logic                  issue, drained, out_free, start_query, wr_vertex;
    logic [CntW-1:0]       n_last;
    logic [StepW-1:0]      step_prev;
    logic [AddrW-1:0]      rd_addr;

    logic signed [CW:0]    dy, dxp, dx, dyp;
    logic signed [2*CW+1:0] lhs, rhs;
    logic                  horiz_hit, vert_hit, straddle, left;

    assign q_pop       = (state_reg == ST_IDLE) && !q_empty;
    assign start_query = q_pop && (q_item.op == pip_pkg::OP_QUERY);
    assign wr_vertex   = q_pop && (q_item.op == pip_pkg::OP_WRITE);

    // read order: last vertex first (as the previous end), then 0..n-1
    assign issue     = (state_reg == ST_WALK) && (step_reg <= StepW'(n_reg));
    assign n_last    = n_reg - CntW'(1);
    assign step_prev = step_reg - StepW'(1);
    assign rd_addr   = (step_reg == '0) ? n_last[AddrW-1:0] : step_prev[AddrW-1:0];
    assign drained   = (state_reg == ST_WALK) && (step_reg > StepW'(n_reg))
                       && !s1_v_reg && !s2_v_reg;
    assign out_free  = !res_valid_reg || !result_stall;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_query)
                begin
                    step_next  = '0;
                    state_next = (vertex_count == '0) ? ST_FINISH : ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (issue)
                begin
                    step_next = step_reg + 1'b1;
                end
                if (drained)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // vertex table
    always_ff @(posedge clk)
    begin
        if (wr_vertex)
        begin
            mem_x[AddrW'(q_item.slot)] <= q_item.x;
            mem_y[AddrW'(q_item.slot)] <= q_item.y;
        end
        if (issue)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
        end
    end

    // stage 1: edge (current read, previous vertex)
    always_comb
    begin
        horiz_hit = (rd_y_reg == py_reg) && (prev_y_reg == py_reg)
                    && (((rd_x_reg <= px_reg) && (px_reg <= prev_x_reg))
                     || ((prev_x_reg <= px_reg) && (px_reg <= rd_x_reg)));
        vert_hit  = (rd_x_reg == px_reg) && (prev_x_reg == px_reg)
                    && (((rd_y_reg <= py_reg) && (py_reg <= prev_y_reg))
                     || ((prev_y_reg <= py_reg) && (py_reg <= rd_y_reg)));
        straddle  = (rd_y_reg > py_reg) != (prev_y_reg > py_reg);
        dy  = {prev_y_reg[CW-1], prev_y_reg} - {rd_y_reg[CW-1], rd_y_reg};
        dxp = {px_reg[CW-1], px_reg}         - {rd_x_reg[CW-1], rd_x_reg};
        dx  = {prev_x_reg[CW-1], prev_x_reg} - {rd_x_reg[CW-1], rd_x_reg};
        dyp = {py_reg[CW-1], py_reg}         - {rd_y_reg[CW-1], rd_y_reg};
        lhs = dxp * dy;
        rhs = dx * dyp;
    end

    // stage 2: crossing side, sense flips for a downward edge
    assign left = s2_neg_reg ? (lhs_reg > rhs_reg) : (lhs_reg < rhs_reg);

    always_ff @(posedge clk)
    begin
        if (start_query)
        begin
            n_reg  <= vertex_count;
            px_reg <= q_item.x;
            py_reg <= q_item.y;
        end
        s1_first_reg <= (step_reg == '0);
        if (s1_v_reg)
        begin
            prev_x_reg      <= rd_x_reg;
            prev_y_reg      <= rd_y_reg;
            s2_edge_hit_reg <= horiz_hit || vert_hit;
            s2_straddle_reg <= straddle;
            s2_neg_reg      <= dy[CW];
            lhs_reg         <= lhs;
            rhs_reg         <= rhs;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            inside_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            s1_v_reg  <= issue;
            s2_v_reg  <= s1_v_reg && !s1_first_reg;
            if (start_query)
            begin
                inside_reg <= 1'b0;
                hit_reg    <= 1'b0;
            end
            else if (s2_v_reg && !hit_reg)
            begin
                // a boundary hit freezes the answer for the remaining edges
                if (s2_edge_hit_reg)
                begin
                    hit_reg <= 1'b1;
                end
                else if (s2_straddle_reg && left)
                begin
                    inside_reg <= !inside_reg;
                end
            end
            if ((state_reg == ST_FINISH) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            res_inside_reg <= hit_reg || inside_reg;
            res_bnd_reg    <= hit_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign inside_res   = res_inside_reg;
    assign on_boundary  = res_bnd_reg;

endmodule

>>> rtl/core/point_in_polygon_test_core.sv
// ============================================================================
// point_in_polygon_test_core - even-odd point-in-polygon test
// Vertex table loaded by write items; query items test one point against it.
// ============================================================================
// Input channel (item_valid/item_stall): kind 0 writes vertex_index with
// (x_coord, y_coord), kind 1 queries that point. Coordinates are signed Q12.4.
// Result channel (result_valid/result_stall): one transfer per query with
// inside_res and on_boundary; write items produce nothing.
// num_vertices sits at APB address 0; the user must write it only while
// idle, and the block itself does not enforce this. Items pass through a
// two-entry queue, so the input keeps accepting while the back end is busy,
// until the queue fills. A write item is stored in the vertex table as the
// back end pops it. A query of n vertices makes n + 1 vertex-table reads,
// one per cycle (the closing vertex first), feeds them through two pipeline
// stages of edge compare, and then loads the result register. The single
// read port of the vertex table sets the rate of one edge per cycle.
// A stalled result holds in its register; the back end waits before loading
// the next result, and the queue then fills and stalls the input.
// Reset clears the count register, the queue and all control state; the
// vertex table is not cleared and must be written before it is queried.
// ============================================================================
module point_in_polygon_test_core #(
    parameter int MaxVertices = pip_pkg::MAX_VERTICES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                kind,
    input  logic [pip_pkg::SLOT_W-1:0]          vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [pip_pkg::COORD_W-1:0]  y_coord,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                inside_res,
    output logic                                on_boundary
);

    localparam int CntW = $clog2(MaxVertices + 1);

    logic                q_push, q_full, q_pop, q_empty;
    pip_pkg::pip_item_t  q_push_item, q_pop_item;
    logic [CntW-1:0]     vertex_count;

    pip_front #(
        .MaxVertices (MaxVertices)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .vertex_index (vertex_index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .q_push       (q_push),
        .q_push_item  (q_push_item),
        .q_full       (q_full),
        .vertex_count (vertex_count)
    );

    pip_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    pip_back #(
        .MaxVertices (MaxVertices)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (q_pop_item),
        .q_pop        (q_pop),
        .vertex_count (vertex_count),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .inside_res   (inside_res),
        .on_boundary  (on_boundary)
    );

endmodule

>>> sim/point_in_polygon_test_checker.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_checker - result checker for the point-in-polygon core
// Watches the APB port and both item channels, keeps its own vertex table and
// vertex count, computes the verdict of each accepted query and compares it
// with the result transfers in order.
// ----------------------------------------------------------------------------
module point_in_polygon_test_checker #(
    parameter logic [2:0] NumVerticesAddr = 3'd0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    input  logic                                pready,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  logic                                kind,
    input  logic [pip_pkg::SLOT_W-1:0]          vertex_index,
    input  logic signed [pip_pkg::COORD_W-1:0]  x_coord,
    input  logic signed [pip_pkg::COORD_W-1:0]  y_coord,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  logic                                inside_res,
    input  logic                                on_boundary,
    output int                                  fail_count,
    output int                                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam logic KIND_QUERY = 1'(OP_QUERY);
    localparam int   MAXV       = MAX_VERTICES_DEF;

    typedef struct packed {
        logic in_poly;
        logic boundary;
    } verdict_t;

    logic signed [COORD_W-1:0] vert_x [MAXV];
    logic signed [COORD_W-1:0] vert_y [MAXV];
    logic [COUNT_W-1:0]        vert_count;
    verdict_t                  verdict_q [$];
    int                        errors;

    // even-odd crossing count, exact cross-multiplied compare, edge (i, i-1)
    function automatic verdict_t ray_cast_verdict(input logic signed [COORD_W-1:0] qx,
                                                  input logic signed [COORD_W-1:0] qy);
        int       n;
        int       i;
        int       j;
        longint   px;
        longint   py;
        longint   xi;
        longint   yi;
        longint   xj;
        longint   yj;
        longint   dy;
        longint   lhs;
        longint   rhs;
        logic     odd;
        logic     left;
        verdict_t v;
        px  = qx;
        py  = qy;
        odd = 1'b0;
        n   = (vert_count > MAXV) ? MAXV : int'(vert_count);
        for (i = 0; i < n; i++)
        begin
            j  = (i == 0) ? n - 1 : i - 1;
            xi = vert_x[i];
            yi = vert_y[i];
            xj = vert_x[j];
            yj = vert_y[j];
            // point on a horizontal edge
            if (yi == py && yj == py && px >= ((xi < xj) ? xi : xj)
                && px <= ((xi > xj) ? xi : xj))
            begin
                v.in_poly  = 1'b1;
                v.boundary = 1'b1;
                return v;
            end
            // point on a vertical edge
            if (xi == xj && xi == px && py >= ((yi < yj) ? yi : yj)
                && py <= ((yi > yj) ? yi : yj))
            begin
                v.in_poly  = 1'b1;
                v.boundary = 1'b1;
                return v;
            end
            if ((yi > py) != (yj > py))
            begin
                dy   = yj - yi;
                lhs  = (px - xi) * dy;
                rhs  = (xj - xi) * (py - yi);
                left = (dy > 0) ? (lhs < rhs) : (lhs > rhs);
                if (left)
                    odd = ~odd;
            end
        end
        v.in_poly  = odd;
        v.boundary = 1'b0;
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        if (!rst_n)
        begin
            vert_count = '0;
            verdict_q.delete();
            errors = 0;
            pending    <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == NumVerticesAddr)
                vert_count = pwdata[COUNT_W-1:0];

            if (item_valid && !item_stall)
            begin
                if (kind == KIND_QUERY)
                    verdict_q.push_back(ray_cast_verdict(x_coord, y_coord));
                else if (vertex_index < MAXV)
                begin
                    vert_x[vertex_index] = x_coord;
                    vert_y[vertex_index] = y_coord;
                end
            end

            if (result_valid && !result_stall)
            begin
                if (verdict_q.size() == 0)
                begin
                    $error("result transfer with no query pending");
                    errors++;
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (inside_res !== want.in_poly)
                    begin
                        $error("inside_res mismatch: expected %0d, actual %0d",
                               want.in_poly, inside_res);
                        errors++;
                    end
                    if (on_boundary !== want.boundary)
                    begin
                        $error("on_boundary mismatch: expected %0d, actual %0d",
                               want.boundary, on_boundary);
                        errors++;
                    end
                end
            end

            // registered so the stimulus side reads settled values
            pending    <= verdict_q.size();
            fail_count <= errors;
        end
    end

endmodule

>>> sim/point_in_polygon_test_core_tb.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_core_tb - testbench top for the point-in-polygon core
// Loads vertex tables and sends query points under random gaps and result
// stalls, changes the vertex count between phases, and reports the verdict
// of the checker that runs beside the core.
// ----------------------------------------------------------------------------
module point_in_polygon_test_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pip_pkg::*;

    localparam logic [2:0] REG_NUM_VERTICES = 3'd0;
    localparam logic       KIND_WRITE       = 1'(OP_WRITE);
    localparam logic       KIND_QUERY       = 1'(OP_QUERY);
    localparam int         MAXV             = MAX_VERTICES_DEF;
    localparam int         RANDOM_ITEMS     = 650;
    localparam int         SETTLE_CYCLES    = 16;
    localparam int         HOLD_CYCLES      = 300;
    localparam int         IDLE_LIMIT       = 3000;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      psel         = 1'b0;
    logic                      penable      = 1'b0;
    logic                      pwrite       = 1'b0;
    logic [2:0]                paddr        = '0;
    logic [31:0]               pwdata       = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      item_valid   = 1'b0;
    logic                      item_stall;
    logic                      kind         = 1'b0;
    logic [SLOT_W-1:0]         vertex_index = '0;
    logic signed [COORD_W-1:0] x_coord      = '0;
    logic signed [COORD_W-1:0] y_coord      = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    logic                      inside_res;
    logic                      on_boundary;
    int                        fail_count;
    int                        pending;

    // copy of the table, only used to aim query points
    logic signed [COORD_W-1:0] poly_x [MAXV];
    logic signed [COORD_W-1:0] poly_y [MAXV];
    int                        cur_count = 0;
    int                        items_sent = 0;
    bit                        burst = 1'b0;
    bit                        hold_req = 1'b0;
    int                        idle_cycles;
    int                        style;
    int                        base_x;
    int                        base_y;
    int                        step;

    point_in_polygon_test_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .vertex_index (vertex_index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .inside_res   (inside_res),
        .on_boundary  (on_boundary)
    );

    point_in_polygon_test_checker #(
        .NumVerticesAddr (REG_NUM_VERTICES)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .kind         (kind),
        .vertex_index (vertex_index),
        .x_coord      (x_coord),
        .y_coord      (y_coord),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .inside_res   (inside_res),
        .on_boundary  (on_boundary),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (burst)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COORD_W-1:0] grid_coord(input int st, input int base);
        int v;
        case (st)
            0: v = base + (int'($urandom_range(0, 8)) - 4) * step;
            1: v = $urandom;
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    3:       v = -1;
                    default: v = $urandom;
                endcase
            end
            default: v = base + int'($urandom_range(0, 64)) - 32;
        endcase
        return COORD_W'(v);
    endfunction

    function automatic int pick_count(input int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            0: return MAXV;
            1: return 127;
            2: return 6;
            3: return 0;
            4: return $urandom_range(MAXV + 1, 126);
            default:
            begin
                if (r < 55)
                    return $urandom_range(1, 8);
                if (r < 80)
                    return $urandom_range(9, 24);
                if (r < 90)
                    return $urandom_range(25, MAXV);
                if (r < 95)
                    return 0;
                return $urandom_range(MAXV, 127);
            end
        endcase
    endfunction

    // one transfer on the item channel; valid stays high when no gap follows
    task automatic send_item(input logic k, input logic [SLOT_W-1:0] idx,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= k;
        vertex_index <= idx;
        x_coord      <= x;
        y_coord      <= y;
        do @(posedge clk); while (item_stall);
        items_sent++;
    endtask

    task automatic put_vertex(input logic [SLOT_W-1:0] idx,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        poly_x[idx] = x;
        poly_y[idx] = y;
        send_item(KIND_WRITE, idx, x, y);
    endtask

    task automatic query_point(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        send_item(KIND_QUERY, SLOT_W'($urandom), x, y);
    endtask

    // drop valid, wait for every result, then let the back end drain writes
    task automatic settle();
        item_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_vertex_count(input int count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NUM_VERTICES;
        pwdata  <= ($urandom & ~32'h7f) | (count & 32'h7f);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_count = count;
    endtask

    // aim at vertices and points next to them, edge midpoints, rays through vertices and random points
    task automatic pick_point(input int m, output logic signed [COORD_W-1:0] px,
                              output logic signed [COORD_W-1:0] py);
        int k;
        int j;
        int r;
        r = (m == 0) ? 7 + $urandom_range(0, 2) : $urandom_range(0, 9);
        k = (m == 0) ? 0 : $urandom_range(0, m - 1);
        j = (k == 0) ? m - 1 : k - 1;
        case (r)
            0, 1, 2:
            begin
                px = poly_x[k];
                py = poly_y[k];
            end
            3:
            begin
                px = poly_x[k] + COORD_W'(int'($urandom_range(0, 2)) - 1);
                py = poly_y[k] + COORD_W'(int'($urandom_range(0, 2)) - 1);
            end
            4, 5:
            begin
                px = COORD_W'((int'(poly_x[k]) + int'(poly_x[j])) >>> 1);
                py = COORD_W'((int'(poly_y[k]) + int'(poly_y[j])) >>> 1);
            end
            6:
            begin
                px = grid_coord(style, base_x);
                py = poly_y[k];
            end
            7:
            begin
                px = grid_coord(style, base_x);
                py = grid_coord(style, base_y);
            end
            8:
            begin
                px = COORD_W'($urandom);
                py = COORD_W'($urandom);
            end
            default:
            begin
                px = grid_coord(2, 0);
                py = grid_coord(2, 0);
            end
        endcase
    endtask

    // result side: random stall runs, plus one long hold-off on request
    initial
    begin
        int run_left;
        int r;
        run_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                hold_req = 1'b0;
                run_left = HOLD_CYCLES - 1;
            end
            else if (run_left == 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    result_stall <= 1'b0;
                    run_left = $urandom_range(0, 7);
                end
                else if (r < 80)
                begin
                    result_stall <= 1'b1;
                    run_left = $urandom_range(0, 2);
                end
                else if (r < 93)
                begin
                    result_stall <= 1'b1;
                    run_left = $urandom_range(3, 11);
                end
                else if (r < 97)
                begin
                    result_stall <= 1'b1;
                    run_left = $urandom_range(29, 79);
                end
                else
                begin
                    result_stall <= 1'b0;
                    run_left = $urandom_range(99, 299);
                end
            end
            else
                run_left--;
        end
    end

    // watchdog: cycles without any transfer on either channel
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int                        phase;
        int                        m;
        int                        nq;
        int                        s;
        int                        start_items;
        logic signed [COORD_W-1:0] qx;
        logic signed [COORD_W-1:0] qy;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // empty polygon right after reset
        query_point(0, 0);
        query_point(-32768, 32767);

        // single vertex: only the vertex itself is on the boundary
        settle();
        set_vertex_count(1);
        put_vertex(0, 16, -48);
        query_point(16, -48);
        query_point(17, -48);

        // axis-aligned square: inside, outside, both edge kinds, corner
        settle();
        set_vertex_count(4);
        put_vertex(0, -160, -160);
        put_vertex(1, 160, -160);
        put_vertex(2, 160, 160);
        put_vertex(3, -160, 160);
        put_vertex(63, 32767, -32768);
        query_point(0, 0);
        query_point(320, 0);
        query_point(0, -160);
        query_point(160, 50);
        query_point(-160, -160);
        query_point(161, 0);

        // full-range triangle, slanted edges stress the wide products
        settle();
        set_vertex_count(3);
        put_vertex(0, -32768, -32768);
        put_vertex(1, 32767, -32768);
        put_vertex(2, 0, 32767);
        query_point(0, 0);
        query_point(32767, 32767);
        query_point(-32768, -32768);
        query_point(16383, 0);
        query_point(-32768, 32767);

        start_items = items_sent;
        phase = 0;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            settle();
            set_vertex_count(pick_count(phase));
            m      = (cur_count > MAXV) ? MAXV : cur_count;
            style  = $urandom_range(0, 3);
            base_x = int'($urandom_range(0, 40000)) - 20000;
            base_y = int'($urandom_range(0, 40000)) - 20000;
            step   = $urandom_range(1, 400);
            burst  = (phase == 2) || ($urandom_range(0, 3) == 0);

            for (s = 0; s < m; s++)
                put_vertex(SLOT_W'(s), grid_coord(style, base_x), grid_coord(style, base_y));

            if (phase == 2)
            begin
                // results held off while queries keep coming: core fills up
                hold_req = 1'b1;
                nq = 12;
            end
            else if (m > 24)
                nq = $urandom_range(3, 6);
            else
                nq = $urandom_range(4, 16);

            repeat (nq)
            begin
                if ($urandom_range(0, 9) == 0)
                    put_vertex(SLOT_W'($urandom), grid_coord(style, base_x),
                               grid_coord(style, base_y));
                pick_point(m, qx, qy);
                query_point(qx, qy);
            end
            phase++;
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
